// File: hdl/assert_macros.svh
// assertion macros used by the rtl of mac_keyed_entry_table_top
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/mket_pkg.sv
// shared types, widths and codes for the mac keyed entry table
// no dependencies
`timescale 1ns / 1ps

package mket_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int KEY_W    = 48;
    localparam int FREQ_W   = 16;
    localparam int STAMP_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [FREQ_W-1:0]  freq;
        logic [STAMP_W-1:0] stamp;
    } rec_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               commit;
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   key;
        logic [FREQ_W-1:0]  nf;
        logic [STAMP_W-1:0] now;
        logic [CNT_W-1:0]   count;
        logic               any_hit;
        rec_t               move_rec;
    } cmd_t;

endpackage

// File: hdl/mket_cell.sv
// one table slot: holds a record, compares its key and takes part in the
// lowest-slot priority chain; depends on mket_pkg
`timescale 1ns / 1ps

module mket_cell (
    input  logic                         clk,
    input  mket_pkg::cmd_t               cmd,
    input  logic [mket_pkg::IDX_W-1:0]   idx,
    input  logic                         hit_in,
    output logic                         hit_out,
    output mket_pkg::rec_t               hit_rec,
    output mket_pkg::rec_t               last_rec
);
    import mket_pkg::*;

    rec_t             rec_reg;
    rec_t             rec_next;
    logic [CNT_W-1:0] idx_ext;
    logic             live;
    logic             match;
    logic             first_hit;
    logic             is_last;
    logic             is_append;
    logic             upd_here;
    logic             rm_here;

    always_comb
    begin
        idx_ext   = CNT_W'(idx);
        live      = idx_ext < cmd.count;
        match     = live && (rec_reg.key == cmd.key);
        // a hit further left wins
        first_hit = match && !hit_in;
        hit_out   = hit_in || match;
        is_last   = live && (idx_ext == (cmd.count - CNT_W'(1)));
        is_append = idx_ext == cmd.count;
        hit_rec   = first_hit ? rec_reg : '0;
        last_rec  = is_last ? rec_reg : '0;

        upd_here  = cmd.commit && (cmd.func == FUNC_UPDATE)
                    && (first_hit || (!cmd.any_hit && is_append));
        rm_here   = cmd.commit && (cmd.func == FUNC_REMOVE) && first_hit && !is_last;

        rec_next = rec_reg;
        if (upd_here)
        begin
            rec_next.key   = cmd.key;
            rec_next.stamp = cmd.now;
            if (cmd.nf != '0)
                rec_next.freq = cmd.nf;
            else if (!first_hit)
                rec_next.freq = '0;
        end
        else if (rm_here)
        begin
            rec_next = cmd.move_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

// File: hdl/mac_keyed_entry_table_top.sv
// mac keyed entry table: a chain of slot cells plus the command controller
// depends on mket_pkg, mket_cell and assert_macros.svh
// result word: the request is registered on accept, then compared and written back in S_EXEC,
// which waits while a stalled result word still holds the output register
// one word at a time: req_stall holds new words off until the S_EXEC compare-and-write commits
// reset clears the entry count and handshake state at once; fill_count and slot contents are not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mac_keyed_entry_table_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [mket_pkg::FUNC_W-1:0]     func,
    input  logic [mket_pkg::KEY_W-1:0]      mac_key,
    input  logic [mket_pkg::FREQ_W-1:0]     new_freq,
    input  logic [mket_pkg::STAMP_W-1:0]    now_stamp,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [mket_pkg::STATUS_W-1:0]   status,
    output logic [mket_pkg::FREQ_W-1:0]     freq_out,
    output logic [mket_pkg::STAMP_W-1:0]    stamp_out,
    output logic [mket_pkg::CNT_W-1:0]      fill_count
);
    import mket_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [FUNC_W-1:0]     func_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [FREQ_W-1:0]     nf_reg;
    logic [STAMP_W-1:0]    now_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [FREQ_W-1:0]     freq_reg;
    logic [FREQ_W-1:0]     freq_next;
    logic [STAMP_W-1:0]    stamp_reg;
    logic [STAMP_W-1:0]    stamp_next;
    logic [CNT_W-1:0]      fill_reg;

    logic                  accept;
    logic                  commit;
    logic                  any_hit;
    logic                  full;
    rec_t                  hit_rec;
    rec_t                  last_rec;
    cmd_t                  cmd;
    logic [ENTRIES:0]      hit_chain;
    rec_t                  cell_hit_rec  [ENTRIES];
    rec_t                  cell_last_rec [ENTRIES];

    assign req_stall  = (state_reg != S_IDLE);
    assign accept     = req_valid && !req_stall;
    assign commit     = (state_reg == S_EXEC) && (!out_valid_reg || !rsp_stall);
    assign rsp_valid  = out_valid_reg;
    assign status     = status_reg;
    assign freq_out   = freq_reg;
    assign stamp_out  = stamp_reg;
    assign fill_count = fill_reg;

    assign hit_chain[0] = 1'b0;
    assign any_hit      = hit_chain[ENTRIES];
    assign full         = (count_reg == CNT_W'(ENTRIES));

    always_comb
    begin
        cmd.commit   = commit;
        cmd.func     = func_reg;
        cmd.key      = key_reg;
        cmd.nf       = nf_reg;
        cmd.now      = now_reg;
        cmd.count    = count_reg;
        cmd.any_hit  = any_hit;
        cmd.move_rec = last_rec;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            mket_cell u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .idx      (IDX_W'(gi)),
                .hit_in   (hit_chain[gi]),
                .hit_out  (hit_chain[gi+1]),
                .hit_rec  (cell_hit_rec[gi]),
                .last_rec (cell_last_rec[gi])
            );
        end
    endgenerate

    // at most one cell drives a nonzero record onto each bus
    always_comb
    begin
        hit_rec  = '0;
        last_rec = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_rec  = hit_rec | cell_hit_rec[i];
            last_rec = last_rec | cell_last_rec[i];
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        freq_next   = '0;
        stamp_next  = '0;
        count_next  = count_reg;
        unique case (func_reg)
            FUNC_LOOKUP:
            begin
                if (any_hit)
                begin
                    freq_next  = hit_rec.freq;
                    stamp_next = hit_rec.stamp;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            FUNC_UPDATE:
            begin
                if (any_hit || !full)
                begin
                    stamp_next = now_reg;
                    if (nf_reg != '0)
                        freq_next = nf_reg;
                    else if (any_hit)
                        freq_next = hit_rec.freq;
                    if (!any_hit)
                        count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            FUNC_REMOVE:
            begin
                if (any_hit)
                begin
                    freq_next  = hit_rec.freq;
                    stamp_next = hit_rec.stamp;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (commit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            key_reg  <= mac_key;
            nf_reg   <= new_freq;
            now_reg  <= now_stamp;
        end
        if (commit)
        begin
            status_reg <= status_next;
            freq_reg   <= freq_next;
            stamp_reg  <= stamp_next;
            fill_reg   <= count_next;
        end
    end

    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(ENTRIES))
    `ASSERT_NEXT(a_commit_gives_word, clk, rst_n, commit, rsp_valid && (fill_count == count_reg))
    `ASSERT_NEXT(a_remove_shrinks, clk, rst_n, commit && (func_reg == FUNC_REMOVE) && any_hit, count_reg == ($past(count_reg) - CNT_W'(1)))
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, (state_reg == S_EXEC) && req_stall)

endmodule

// File: bench/mac_keyed_entry_table_top_tb.sv
// self-checking bench for mac_keyed_entry_table_top: directed table, then random traffic
// mirrors the mac table in a local model and checks every result word in order
// depends on mket_pkg and the rtl of mac_keyed_entry_table_top
`timescale 1ns / 1ps

module mac_keyed_entry_table_top_tb;
    import mket_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;  // unused selector, must be ignored
    localparam int POOL_SIZE  = 24;
    localparam int PHASE_WORDS = 417;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [STATUS_W-1:0] stat;
        logic [FREQ_W-1:0]   freq;
        logic [STAMP_W-1:0]  stamp;
        logic [CNT_W-1:0]    count;
    } table_rsp_t;

    typedef struct {
        logic [FUNC_W-1:0]  op;
        logic [KEY_W-1:0]   key;
        logic [FREQ_W-1:0]  nf;
        logic [STAMP_W-1:0] now;
        bit                 typed;
        table_rsp_t         rsp;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [FUNC_W-1:0]   func = '0;
    logic [KEY_W-1:0]    mac_key = '0;
    logic [FREQ_W-1:0]   new_freq = '0;
    logic [STAMP_W-1:0]  now_stamp = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [FREQ_W-1:0]   freq_out;
    logic [STAMP_W-1:0]  stamp_out;
    logic [CNT_W-1:0]    fill_count;

    // local copy of the table
    logic [KEY_W-1:0]   slot_key [ENTRIES];
    logic [FREQ_W-1:0]  slot_freq [ENTRIES];
    logic [STAMP_W-1:0] slot_stamp [ENTRIES];
    int                 live_count = 0;

    table_rsp_t  pending_rsp [$];
    table_rsp_t  oldest;
    dir_row_t    dir_rows [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int          errors = 0;
    int          cycle_count = 0;
    int          tx_idle = 0;
    int          phase_no = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    mac_keyed_entry_table_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .func       (func),
        .mac_key    (mac_key),
        .new_freq   (new_freq),
        .now_stamp  (now_stamp),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .freq_out   (freq_out),
        .stamp_out  (stamp_out),
        .fill_count (fill_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic table_rsp_t mk_rsp(input logic [STATUS_W-1:0] st,
                                          input logic [FREQ_W-1:0] fr,
                                          input logic [STAMP_W-1:0] sp,
                                          input int cnt);
        table_rsp_t r;
        r.stat  = st;
        r.freq  = fr;
        r.stamp = sp;
        r.count = CNT_W'(cnt);
        return r;
    endfunction

    function automatic dir_row_t mk_row(input logic [FUNC_W-1:0] op,
                                        input logic [KEY_W-1:0] key,
                                        input logic [FREQ_W-1:0] nf,
                                        input logic [STAMP_W-1:0] now,
                                        input bit typed,
                                        input table_rsp_t rsp);
        dir_row_t d;
        d.op    = op;
        d.key   = key;
        d.nf    = nf;
        d.now   = now;
        d.typed = typed;
        d.rsp   = rsp;
        return d;
    endfunction

    // applies one word to the local table and returns the result it should give
    function automatic void table_apply(input logic [FUNC_W-1:0] op,
                                        input logic [KEY_W-1:0] key,
                                        input logic [FREQ_W-1:0] nf,
                                        input logic [STAMP_W-1:0] now,
                                        output table_rsp_t r);
        int slot;
        int last;
        slot = -1;
        r = mk_rsp(ST_OK, '0, '0, 0);
        // lowest matching valid slot
        for (int i = 0; i < live_count; i++)
        begin
            if (slot < 0 && slot_key[i] == key)
                slot = i;
        end
        case (op)
            FUNC_LOOKUP:
            begin
                if (slot < 0)
                    r.stat = ST_MISS;
                else
                begin
                    r.freq  = slot_freq[slot];
                    r.stamp = slot_stamp[slot];
                end
            end
            FUNC_UPDATE:
            begin
                if (slot < 0)
                begin
                    if (live_count >= ENTRIES)
                        r.stat = ST_FULL;
                    else
                    begin
                        slot = live_count;
                        slot_freq[slot]  = '0;
                        slot_stamp[slot] = '0;
                        live_count++;
                    end
                end
                if (slot >= 0)
                begin
                    slot_key[slot] = key;
                    if (nf != '0)
                        slot_freq[slot] = nf;
                    slot_stamp[slot] = now;
                    r.freq  = slot_freq[slot];
                    r.stamp = slot_stamp[slot];
                end
            end
            FUNC_REMOVE:
            begin
                if (slot < 0)
                    r.stat = ST_MISS;
                else
                begin
                    last = live_count - 1;
                    r.freq  = slot_freq[slot];
                    r.stamp = slot_stamp[slot];
                    // last record fills the hole
                    if (slot != last)
                    begin
                        slot_key[slot]   = slot_key[last];
                        slot_freq[slot]  = slot_freq[last];
                        slot_stamp[slot] = slot_stamp[last];
                    end
                    live_count = last;
                end
            end
            default:
            begin
            end
        endcase
        r.count = CNT_W'(live_count);
    endfunction

    task automatic send_word(input logic [FUNC_W-1:0] op,
                             input logic [KEY_W-1:0] key,
                             input logic [FREQ_W-1:0] nf,
                             input logic [STAMP_W-1:0] now,
                             input bit typed,
                             input table_rsp_t typed_rsp);
        table_rsp_t r;
        while ($urandom_range(0, 99) < tx_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= op;
        mac_key   <= key;
        new_freq  <= nf;
        now_stamp <= now;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        table_apply(op, key, nf, now, r);
        if (typed)
            pending_rsp.push_back(typed_rsp);
        else
            pending_rsp.push_back(r);
    endtask

    // receiver: checks result words and drives its own stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                oldest = pending_rsp.pop_front();
                if (status !== oldest.stat)
                begin
                    $error("status: expected %0d, got %0d", oldest.stat, status);
                    errors++;
                end
                if (freq_out !== oldest.freq)
                begin
                    $error("freq_out: expected %0h, got %0h", oldest.freq, freq_out);
                    errors++;
                end
                if (stamp_out !== oldest.stamp)
                begin
                    $error("stamp_out: expected %0h, got %0h", oldest.stamp, stamp_out);
                    errors++;
                end
                if (fill_count !== oldest.count)
                begin
                    $error("fill_count: expected %0d, got %0d", oldest.count, fill_count);
                    errors++;
                end
            end
        end
        // one long hold-off at the start of the first random phase
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (phase_no == 1 && !hold_done)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < (phase_no == 1 ? 49 : phase_no == 2 ? 13 : 0));
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [63:0]        wide;
        logic [FUNC_W-1:0]  op;
        logic [KEY_W-1:0]   key;
        logic [FREQ_W-1:0]  nf;
        int                 pick;
        bit                 fill_bias;
        table_rsp_t         none;

        none = mk_rsp(ST_OK, '0, '0, 0);
        dir_rows.push_back(mk_row(FUNC_LOOKUP, '0, '0, '0, 1, mk_rsp(ST_MISS, '0, '0, 0)));
        dir_rows.push_back(mk_row(FUNC_REMOVE, '1, '1, '1, 1, mk_rsp(ST_MISS, '0, '0, 0)));
        dir_rows.push_back(mk_row(FUNC_SPARE, '1, '1, '1, 1, mk_rsp(ST_OK, '0, '0, 0)));
        dir_rows.push_back(mk_row(FUNC_UPDATE, '1, '1, '1, 1, mk_rsp(ST_OK, '1, '1, 1)));
        dir_rows.push_back(mk_row(FUNC_UPDATE, '0, '0, '0, 1, mk_rsp(ST_OK, '0, '0, 2)));
        dir_rows.push_back(mk_row(FUNC_LOOKUP, '1, '0, '0, 1, mk_rsp(ST_OK, '1, '1, 2)));
        // zero frequency keeps the stored one
        dir_rows.push_back(mk_row(FUNC_UPDATE, '1, '0, 32'd1, 0, none));
        dir_rows.push_back(mk_row(FUNC_LOOKUP, '0, '1, '1, 0, none));
        for (int i = 0; i < ENTRIES - 2; i++)
            dir_rows.push_back(mk_row(FUNC_UPDATE, 48'h5A5A_0000_0000 + i,
                                      FREQ_W'(2400 + 5 * i), STAMP_W'(1000 + i), 0, none));
        dir_rows.push_back(mk_row(FUNC_UPDATE, 48'd1, 16'd5180, 32'd77, 1,
                                  mk_rsp(ST_FULL, '0, '0, ENTRIES)));
        // slot one, then slot zero, gets the last record moved in
        dir_rows.push_back(mk_row(FUNC_REMOVE, '0, '0, '0, 0, none));
        dir_rows.push_back(mk_row(FUNC_REMOVE, '1, '0, '0, 0, none));
        dir_rows.push_back(mk_row(FUNC_LOOKUP, 48'h5A5A_0000_0000 + ENTRIES - 4,
                                  '0, '0, 0, none));

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            wide = {$urandom, $urandom};
            key_pool[i] = wide[KEY_W-1:0];
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].nf, dir_rows[i].now,
                      dir_rows[i].typed, dir_rows[i].rsp);

        for (int ph = 1; ph <= 3; ph++)
        begin
            phase_no <= ph;
            tx_idle = (ph == 1) ? 13 : (ph == 2) ? 49 : 0;
            fill_bias = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // pick a filling or draining bias at random every 50 words so both empty and full are hit
                if (n % 50 == 0)
                    fill_bias = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    op = FUNC_SPARE;
                else if (pick < 35)
                    op = FUNC_LOOKUP;
                else if (pick < (fill_bias ? 80 : 50))
                    op = FUNC_UPDATE;
                else
                    op = FUNC_REMOVE;
                if ($urandom_range(0, 99) < 85)
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                begin
                    wide = {$urandom, $urandom};
                    key = wide[KEY_W-1:0];
                end
                nf = ($urandom_range(0, 3) == 0) ? '0 : FREQ_W'($urandom);
                send_word(op, key, nf, $urandom, 0, none);
            end
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
